[hw/rtl/normal_frame_vector_rotation_top_defines.svh]
// Assertion macros shared by the normal frame vector rotation RTL.
`ifndef NORMAL_FRAME_VECTOR_ROTATION_TOP_DEFINES_SVH
`define NORMAL_FRAME_VECTOR_ROTATION_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define NFVR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define NFVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/nfvr_pkg.sv]
// Types and constants shared by the normal frame vector rotation RTL.
package nfvr_pkg;

    localparam int WIDE_W      = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STAGES = 32;
    localparam int APB_ADDR_W  = 3;

    // Register indexes (address bit 2)
    localparam logic REG_DIM_MODE  = 1'b0;
    localparam logic REG_DEG_LIMIT = 1'b1;

    localparam logic [1:0]  DIM_MODE_RESET  = 2'd3;
    localparam logic [30:0] DEG_LIMIT_RESET = 31'd11;
    localparam logic [1:0]  MODE_PLANAR     = 2'd2;

    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_BACK    = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] vec_a;
        logic signed [31:0] vec_b;
        logic signed [31:0] vec_c;
    } nfvr_item_t;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic               degenerate_used;
        logic               saturated;
    } nfvr_result_t;

    // Sideband that travels with each item down the pipeline
    typedef struct packed {
        logic               op;
        logic               planar;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] va;
        logic signed [31:0] vb;
        logic signed [31:0] vc;
        logic [ROOT_W-1:0]  root;
        logic               degen;
    } nfvr_side_t;

endpackage

[hw/rtl/nfvr_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module nfvr_isqrt
    import nfvr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [WIDE_W-1:0] x,
    output logic [ROOT_W-1:0] root
);

    logic [WIDE_W-1:0] rem_reg [0:SQRT_STAGES-2];
    logic [WIDE_W-1:0] res_reg [0:SQRT_STAGES-1];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        localparam logic [WIDE_W-1:0] BitVal = WIDE_W'(1) << (WIDE_W - 2 - 2 * i);
        logic [WIDE_W-1:0] rem_in;
        logic [WIDE_W-1:0] res_in;
        logic [WIDE_W-1:0] trial;
        logic [WIDE_W-1:0] rem_next;
        logic [WIDE_W-1:0] res_next;

        if (i == 0)
        begin : g_first
            assign rem_in = x;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign res_in = res_reg[i-1];
        end

        assign trial = res_in + BitVal;

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BitVal;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[i] <= res_next;
            end
        end

        if (i < SQRT_STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                end
            end
        end
        else
        begin : g_norem
            // last stage keeps only the root
        end
    end

    assign root = res_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

[hw/rtl/nfvr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module nfvr_div
    import nfvr_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [WIDE_W-1:0]    num,
    input  logic [WIDE_W-1:0]    den,
    output logic [FRAC_BITS:0]   quo
);

    localparam int Stages = FRAC_BITS + 1;

    logic [WIDE_W-1:0]  rem_reg [0:Stages-2];
    logic [WIDE_W-1:0]  den_reg [0:Stages-2];
    logic [FRAC_BITS:0] quo_reg [0:Stages-1];

    for (genvar i = 0; i < Stages; i++)
    begin : g_stage
        localparam int Shift = FRAC_BITS - i;
        logic [WIDE_W-1:0]  rem_in;
        logic [WIDE_W-1:0]  den_in;
        logic [FRAC_BITS:0] quo_in;
        logic [WIDE_W-1:0]  dsh;
        logic [WIDE_W-1:0]  rem_next;
        logic [FRAC_BITS:0] quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign dsh = den_in << Shift;

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= dsh)
            begin
                rem_next        = rem_in - dsh;
                quo_next[Shift] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= quo_next;
            end
        end

        if (i < Stages - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_in;
                end
            end
        end
        else
        begin : g_nocarry
            // last stage keeps only the quotient
        end
    end

    assign quo = quo_reg[Stages-1];

endmodule

[hw/rtl/normal_frame_vector_rotation_top.sv]
// Top level of the normal frame vector rotation pipeline.
//
//  Port group  Dir  Handshake                      Carries
//  item        in   item_valid / item_stall        nfvr_item_t (op, normal, vector)
//  result      out  result_valid / result_stall    nfvr_result_t (rotated vector, flags)
//  apb         in   psel / penable / pwrite        dimension_mode, degenerate_limit
//
// One transfer is taken every cycle unless a stalled result holds the pipe; each item
// spends NORMAL_FRAC_BITS + 42 register stages (72 at the default), set by the 32-stage
// square root of nx^2 + ny^2 and the NORMAL_FRAC_BITS + 1 stage ratio dividers after it.
// Reset clears the valid bits and loads the config reset values; nothing else is reset.
// A stalled result holds the whole pipe in place, and item_stall follows at once.
`include "normal_frame_vector_rotation_top_defines.svh"

module normal_frame_vector_rotation_top
    import nfvr_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 30,
    parameter int VEC_WIDTH        = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  nfvr_item_t            item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output nfvr_result_t          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Stage positions along the pipe
    localparam int StIn    = 0;
    localparam int StSq    = StIn + 1;
    localparam int StSum   = StSq + 1;
    localparam int StRoot  = StSum + SQRT_STAGES;
    localparam int StDivIn = StRoot + 1;
    localparam int StQuo   = StDivIn + NORMAL_FRAC_BITS + 1;
    localparam int StR     = StQuo + 1;
    localparam int StK     = StR + 1;
    localparam int StCoef  = StK + 1;
    localparam int StProd  = StCoef + 1;
    localparam int StOut   = StProd + 1;

    localparam logic signed [33:0] CoefOne = 34'sd1 <<< NORMAL_FRAC_BITS;
    localparam logic signed [63:0] KRound  = 64'sd1 <<< (NORMAL_FRAC_BITS - 1);
    localparam logic signed [67:0] ORound  = 68'sd1 <<< (NORMAL_FRAC_BITS - 1);
    localparam logic signed [67:0] SatMax  = (68'sd1 <<< (VEC_WIDTH - 1)) - 68'sd1;
    localparam logic signed [67:0] SatMin  = -SatMax - 68'sd1;
    localparam logic [NORMAL_FRAC_BITS:0] QuoOne = {1'b1, {NORMAL_FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers (APB, zero wait states)
    // ------------------------------------------------------------------
    logic [1:0]  dim_mode_reg;
    logic [30:0] deg_limit_reg;
    logic        cfg_wr;
    logic        cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_mode_reg  <= DIM_MODE_RESET;
            deg_limit_reg <= DEG_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DIM_MODE:  dim_mode_reg  <= pwdata[1:0];
                REG_DEG_LIMIT: deg_limit_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DIM_MODE:  prdata = {30'd0, dim_mode_reg};
            REG_DEG_LIMIT: prdata = {1'b0, deg_limit_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipe control: every stage advances together unless the result stalls
    // ------------------------------------------------------------------
    logic adv;

    logic [StOut:0] vld_reg;
    logic [StOut:0] vld_next;
    nfvr_side_t     side_reg  [0:StOut];
    nfvr_side_t     side_next [0:StOut];

    assign adv        = !(vld_reg[StOut] && result_stall);
    assign item_stall = !adv;

    logic [ROOT_W-1:0] root;

    // Shift the sideband along; the root and degenerate flag join it once known
    always_comb
    begin
        vld_next[StIn]         = item_valid;
        side_next[StIn].op     = item.op;
        side_next[StIn].planar = (dim_mode_reg == MODE_PLANAR);
        side_next[StIn].nx     = item.normal_x;
        side_next[StIn].ny     = item.normal_y;
        side_next[StIn].nz     = item.normal_z;
        side_next[StIn].va     = item.vec_a;
        side_next[StIn].vb     = item.vec_b;
        side_next[StIn].vc     = item.vec_c;
        side_next[StIn].root   = '0;
        side_next[StIn].degen  = 1'b0;
        for (int k = 1; k <= StOut; k++)
        begin
            vld_next[k]  = vld_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
        side_next[StDivIn].root  = root;
        side_next[StDivIn].degen = !side_reg[StRoot].planar &&
                                   (root <= {1'b0, deg_limit_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= StOut; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horizontal length d = isqrt(nx^2 + ny^2)
    // ------------------------------------------------------------------
    logic signed [63:0] sqx_full;
    logic signed [63:0] sqy_full;
    logic [62:0]        sqx_reg;
    logic [62:0]        sqy_reg;
    logic [WIDE_W-1:0]  x_reg;

    assign sqx_full = side_reg[StIn].nx * side_reg[StIn].nx;
    assign sqy_full = side_reg[StIn].ny * side_reg[StIn].ny;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= sqx_full[62:0];
            sqy_reg <= sqy_full[62:0];
            x_reg   <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    nfvr_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (adv),
        .x    (x_reg),
        .root (root)
    );

    // ------------------------------------------------------------------
    // Ratios r0 = nx/d, r1 = ny/d, rounded half away from zero
    // ------------------------------------------------------------------
    logic [31:0]             mag0;
    logic [31:0]             mag1;
    logic [WIDE_W-1:0]       num0_reg;
    logic [WIDE_W-1:0]       num1_reg;
    logic [WIDE_W-1:0]       den_reg;
    logic [NORMAL_FRAC_BITS:0] quo0;
    logic [NORMAL_FRAC_BITS:0] quo1;

    assign mag0 = side_reg[StRoot].nx[31] ? (~side_reg[StRoot].nx + 32'd1) : side_reg[StRoot].nx;
    assign mag1 = side_reg[StRoot].ny[31] ? (~side_reg[StRoot].ny + 32'd1) : side_reg[StRoot].ny;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num0_reg <= ({32'd0, mag0} << (NORMAL_FRAC_BITS + 1)) + {32'd0, root};
            num1_reg <= ({32'd0, mag1} << (NORMAL_FRAC_BITS + 1)) + {32'd0, root};
            den_reg  <= {31'd0, root, 1'b0};
        end
    end

    nfvr_div #(.FRAC_BITS(NORMAL_FRAC_BITS)) u_div0
    (
        .clk (clk),
        .en  (adv),
        .num (num0_reg),
        .den (den_reg),
        .quo (quo0)
    );

    nfvr_div #(.FRAC_BITS(NORMAL_FRAC_BITS)) u_div1
    (
        .clk (clk),
        .en  (adv),
        .num (num1_reg),
        .den (den_reg),
        .quo (quo1)
    );

    // Give the ratios the sign of the normal, then form r*nz
    logic signed [31:0] qx0;
    logic signed [31:0] qx1;
    logic signed [31:0] r0_reg;
    logic signed [31:0] r1_reg;
    logic signed [31:0] r0k_reg;
    logic signed [31:0] r1k_reg;
    logic signed [63:0] kp0_reg;
    logic signed [63:0] kp1_reg;

    assign qx0 = 32'(quo0);
    assign qx1 = 32'(quo1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg  <= side_reg[StQuo].nx[31] ? -qx0 : qx0;
            r1_reg  <= side_reg[StQuo].ny[31] ? -qx1 : qx1;
            kp0_reg <= r0_reg * side_reg[StR].nz;
            kp1_reg <= r1_reg * side_reg[StR].nz;
            r0k_reg <= r0_reg;
            r1k_reg <= r1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Coefficient matrix, row-major: outputs a, b, c by inputs va, vb, vc
    // ------------------------------------------------------------------
    logic signed [63:0] k0_full;
    logic signed [63:0] k1_full;
    logic signed [33:0] k0;
    logic signed [33:0] k1;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic signed [33:0] cr0;
    logic signed [33:0] cr1;
    logic signed [33:0] cd;
    logic signed [33:0] cs;
    logic signed [33:0] coef_next [0:8];
    logic signed [33:0] coef_reg  [0:8];

    assign k0_full = (kp0_reg + KRound) >>> NORMAL_FRAC_BITS;
    assign k1_full = (kp1_reg + KRound) >>> NORMAL_FRAC_BITS;
    assign k0      = k0_full[33:0];
    assign k1      = k1_full[33:0];
    assign cx      = 34'(side_reg[StK].nx);
    assign cy      = 34'(side_reg[StK].ny);
    assign cz      = 34'(side_reg[StK].nz);
    assign cr0     = 34'(r0k_reg);
    assign cr1     = 34'(r1k_reg);
    assign cd      = {2'b00, side_reg[StK].root};
    assign cs      = (side_reg[StK].op == OP_BACK) ? -cz : cz;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            coef_next[i] = '0;
        end
        if (side_reg[StK].planar)
        begin
            coef_next[0] = cx;
            coef_next[4] = cx;
            coef_next[8] = CoefOne;
            if (side_reg[StK].op == OP_BACK)
            begin
                coef_next[1] = -cy;
                coef_next[3] = cy;
            end
            else
            begin
                coef_next[1] = cy;
                coef_next[3] = -cy;
            end
        end
        else if (side_reg[StK].degen)
        begin
            // fixed rotation about the y axis
            coef_next[2] = cs;
            coef_next[4] = CoefOne;
            coef_next[6] = -cs;
        end
        else if (side_reg[StK].op == OP_FORWARD)
        begin
            coef_next[0] = cx;
            coef_next[1] = cy;
            coef_next[2] = cz;
            coef_next[3] = -cr1;
            coef_next[4] = cr0;
            coef_next[6] = -k0;
            coef_next[7] = -k1;
            coef_next[8] = cd;
        end
        else
        begin
            coef_next[0] = cx;
            coef_next[1] = -cr1;
            coef_next[2] = -k0;
            coef_next[3] = cy;
            coef_next[4] = cr0;
            coef_next[5] = -k1;
            coef_next[6] = cz;
            coef_next[8] = cd;
        end
    end

    // ------------------------------------------------------------------
    // Nine exact products, then row sums with one rounding and saturation
    // ------------------------------------------------------------------
    logic signed [31:0] vcol [0:2];
    logic signed [65:0] prod_next [0:8];
    logic signed [65:0] prod_reg  [0:8];

    assign vcol[0] = side_reg[StCoef].va;
    assign vcol[1] = side_reg[StCoef].vb;
    assign vcol[2] = side_reg[StCoef].vc;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[3*r+c] = coef_reg[3*r+c] * vcol[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                coef_reg[i] <= coef_next[i];
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    logic signed [67:0] acc      [0:2];
    logic signed [67:0] lane_t   [0:2];
    logic signed [67:0] lane_val [0:2];
    logic [2:0]         lane_sat;
    nfvr_result_t       out_next;
    nfvr_result_t       out_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 68'(prod_reg[3*r]) + 68'(prod_reg[3*r+1]) + 68'(prod_reg[3*r+2]) + ORound;
            lane_t[r] = acc[r] >>> NORMAL_FRAC_BITS;
            if (lane_t[r] > SatMax)
            begin
                lane_val[r] = SatMax;
                lane_sat[r] = 1'b1;
            end
            else if (lane_t[r] < SatMin)
            begin
                lane_val[r] = SatMin;
                lane_sat[r] = 1'b1;
            end
            else
            begin
                lane_val[r] = lane_t[r];
                lane_sat[r] = 1'b0;
            end
        end
        out_next.out_a           = lane_val[0][31:0];
        out_next.out_b           = lane_val[1][31:0];
        out_next.out_c           = lane_val[2][31:0];
        out_next.degenerate_used = side_reg[StProd].degen;
        out_next.saturated       = |lane_sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = vld_reg[StOut];
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `NFVR_ASSERT_NEXT(a_pipe_holds, !adv, $stable(vld_reg), "valid bits moved while held")
    `NFVR_ASSERT_NOW(a_root_bound, vld_reg[StRoot], (root >= mag0) && (root >= mag1), "root below a normal component")
    `NFVR_ASSERT_NOW(a_ratio_bound, vld_reg[StQuo] && !side_reg[StQuo].degen && (side_reg[StQuo].root != '0), (quo0 <= QuoOne) && (quo1 <= QuoOne), "ratio above one")
    `NFVR_ASSERT_NOW(a_degen_3d, result_valid && result.degenerate_used, !side_reg[StOut].planar, "degenerate flag in planar mode")

endmodule
